### hdl/hnms_pkg.sv
// shared constants, codes and control types of the near-match search unit
package hnms_pkg;

  // store geometry
  localparam int MAX_ENTRIES = 4096;
  localparam int WORD_W      = 64;
  localparam int ROW_W       = 4 * WORD_W;
  localparam int ADDR_W      = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int BIT_CNT_W   = $clog2(ROW_W);

  // field widths
  localparam int CFG_CNT_W   = 13;
  localparam int CFG_IDX_W   = 2;
  localparam int DIST_W      = 4;
  localparam int POP_W       = $clog2(WORD_W + 1);
  localparam int SUM_W       = $clog2(ROW_W + 1);

  // generator shift amounts and the output bit taken
  localparam int GEN_SHL     = 23;
  localparam int GEN_SHR_X   = 17;
  localparam int GEN_SHR_Y   = 26;
  localparam int GEN_BIT     = 32;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SEED_FIRST  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SEED_SECOND = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ENTRY_COUNT = 2'd2;

  // item commands
  localparam logic CMD_BUILD = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic start_build;
    logic start_query;
    logic gen_step;
    logic issue;
    logic finish;
  } hnms_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic build_done;
    logic issue_done;
    logic pipe_empty;
    logic hit;
    logic out_busy;
  } hnms_sts_t;

  // population count of one word as a tree of pairwise adds
  function automatic logic [POP_W-1:0] pop64(input logic [WORD_W-1:0] v);
    logic [1:0] l1 [32];
    logic [2:0] l2 [16];
    logic [3:0] l3 [8];
    logic [4:0] l4 [4];
    logic [5:0] l5 [2];
    for (int i = 0; i < 32; i++) l1[i] = {1'b0, v[2*i]} + {1'b0, v[2*i+1]};
    for (int i = 0; i < 16; i++) l2[i] = {1'b0, l1[2*i]} + {1'b0, l1[2*i+1]};
    for (int i = 0; i < 8; i++)  l3[i] = {1'b0, l2[2*i]} + {1'b0, l2[2*i+1]};
    for (int i = 0; i < 4; i++)  l4[i] = {1'b0, l3[2*i]} + {1'b0, l3[2*i+1]};
    for (int i = 0; i < 2; i++)  l5[i] = {1'b0, l4[2*i]} + {1'b0, l4[2*i+1]};
    return {1'b0, l5[0]} + {1'b0, l5[1]};
  endfunction

endpackage

### hdl/hnms_ram.sv
// generic single-write, single-read ram with registered read data
module hnms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic                                       re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hdl/hnms_ctrl.sv
// controller state machine: sequences build, scan and result hand-off
module hnms_ctrl
  import hnms_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_cmd,
  output logic      in_stall,
  input  hnms_sts_t sts,
  output hnms_cmd_t cmd
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_BUILD = 4'b0010,
    ST_SCAN  = 4'b0100,
    ST_DONE  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  // input is taken only between items
  assign in_stall = (state_r != ST_IDLE);

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_cmd == CMD_BUILD) begin
            cmd.start_build = 1'b1;
            state_nxt       = ST_BUILD;
          end else begin
            cmd.start_query = 1'b1;
            state_nxt       = ST_SCAN;
          end
        end
      end
      ST_BUILD: begin
        if (sts.build_done) begin
          state_nxt = ST_DONE;
        end else begin
          cmd.gen_step = 1'b1;
        end
      end
      ST_SCAN: begin
        if (sts.hit || (sts.issue_done && sts.pipe_empty)) begin
          state_nxt = ST_DONE;
        end else if (!sts.issue_done) begin
          cmd.issue = 1'b1;
        end
      end
      ST_DONE: begin
        if (!sts.out_busy) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### hdl/hnms_dp.sv
// datapath: config registers, generator, entry store, compare pipeline, result beat
module hnms_dp
  import hnms_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [WORD_W-1:0]    cfg_data,
  input  logic [WORD_W-1:0]    in_query_word0,
  input  logic [WORD_W-1:0]    in_query_word1,
  input  logic [WORD_W-1:0]    in_query_word2,
  input  logic [WORD_W-1:0]    in_query_word3,
  input  logic [DIST_W-1:0]    in_max_distance,
  output logic                 out_valid,
  output logic                 out_found,
  input  logic                 out_stall,
  input  hnms_cmd_t            cmd,
  output hnms_sts_t            sts
);

  localparam int EXT_W = CNT_W + CFG_CNT_W;

  logic [WORD_W-1:0]    seed_first_r, seed_second_r;
  logic [CFG_CNT_W-1:0] entry_count_r;
  logic [WORD_W-1:0]    gen_a_r, gen_b_r;
  logic [ROW_W-2:0]     row_r;
  logic [BIT_CNT_W-1:0] bit_cnt_r;
  logic [CNT_W-1:0]     ent_cnt_r, built_cnt_r;
  logic [ROW_W-1:0]     query_r;
  logic [DIST_W-1:0]    limit_r;
  logic                 query_mode_r, prev_r, hit_r;
  logic                 rd_vld_r, cnt_vld_r;
  logic [POP_W-1:0]     pop_r [4];
  logic                 out_valid_r, out_found_r;

  logic [WORD_W-1:0]    gen_x, gen_b_nxt;
  logic [GEN_BIT:0]     gen_sum;
  logic                 gen_bit;
  logic [ROW_W-1:0]     row_full, rdata, diff;
  logic [CNT_W-1:0]     count_sat;
  logic [SUM_W-1:0]     ham_dist;
  logic                 ram_we, answer;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_first_r  <= '0;
      seed_second_r <= '0;
      entry_count_r <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_SEED_FIRST:  seed_first_r  <= cfg_data;
        REG_SEED_SECOND: seed_second_r <= cfg_data;
        REG_ENTRY_COUNT: entry_count_r <= cfg_data[CFG_CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // entry count saturated to the store size
  always_comb begin
    if (EXT_W'(entry_count_r) > EXT_W'(MAX_ENTRIES)) begin
      count_sat = CNT_W'(MAX_ENTRIES);
    end else begin
      count_sat = CNT_W'(entry_count_r);
    end
  end

  // xorshift128+ step; only bit 32 of the sum is needed
  always_comb begin
    gen_x     = gen_a_r ^ (gen_a_r << GEN_SHL);
    gen_b_nxt = gen_x ^ gen_b_r ^ (gen_x >> GEN_SHR_X) ^ (gen_b_r >> GEN_SHR_Y);
    gen_sum   = {1'b0, gen_b_nxt[GEN_BIT-1:0]} + {1'b0, gen_b_r[GEN_BIT-1:0]};
    gen_bit   = gen_b_nxt[GEN_BIT] ^ gen_b_r[GEN_BIT] ^ gen_sum[GEN_BIT];
  end

  assign row_full = {row_r, gen_bit};
  assign ram_we   = cmd.gen_step && (bit_cnt_r == BIT_CNT_W'(ROW_W - 1));

  // generator, row shifter and entry counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gen_a_r     <= '0;
      gen_b_r     <= '0;
      bit_cnt_r   <= '0;
      ent_cnt_r   <= '0;
      built_cnt_r <= '0;
    end else if (cmd.start_build) begin
      gen_a_r     <= seed_first_r;
      gen_b_r     <= seed_second_r;
      bit_cnt_r   <= '0;
      ent_cnt_r   <= '0;
      built_cnt_r <= count_sat;
    end else if (cmd.start_query) begin
      ent_cnt_r   <= '0;
    end else if (cmd.gen_step) begin
      gen_a_r   <= gen_b_r;
      gen_b_r   <= gen_b_nxt;
      bit_cnt_r <= bit_cnt_r + 1'b1;
      if (ram_we) begin
        ent_cnt_r <= ent_cnt_r + 1'b1;
      end
    end else if (cmd.issue) begin
      ent_cnt_r <= ent_cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.gen_step) begin
      row_r <= row_full[ROW_W-2:0];
    end
  end

  // entry store, one row per entry
  hnms_ram #(
    .WIDTH (ROW_W),
    .DEPTH (MAX_ENTRIES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ent_cnt_r[ADDR_W-1:0]),
    .wdata (row_full),
    .re    (cmd.issue),
    .raddr (ent_cnt_r[ADDR_W-1:0]),
    .rdata (rdata)
  );

  // query capture, inverted after a positive answer
  always_ff @(posedge clk) begin
    if (cmd.start_query) begin
      query_r <= {in_query_word0, in_query_word1, in_query_word2, in_query_word3}
                 ^ {ROW_W{prev_r}};
      limit_r <= in_max_distance;
    end
  end

  // compare pipeline: read, per-word popcount, sum and compare
  assign diff = rdata ^ query_r;
  assign ham_dist = SUM_W'(pop_r[0]) + SUM_W'(pop_r[1]) + SUM_W'(pop_r[2]) + SUM_W'(pop_r[3]);

  always_ff @(posedge clk) begin
    for (int w = 0; w < 4; w++) begin
      pop_r[w] <= pop64(diff[w*WORD_W +: WORD_W]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r     <= 1'b0;
      cnt_vld_r    <= 1'b0;
      hit_r        <= 1'b0;
      query_mode_r <= 1'b0;
    end else if (cmd.start_build || cmd.start_query) begin
      rd_vld_r     <= 1'b0;
      cnt_vld_r    <= 1'b0;
      hit_r        <= 1'b0;
      query_mode_r <= cmd.start_query;
    end else begin
      rd_vld_r  <= cmd.issue;
      cnt_vld_r <= rd_vld_r;
      if (cnt_vld_r && (ham_dist <= SUM_W'(limit_r))) begin
        hit_r <= 1'b1;
      end
    end
  end

  assign answer = query_mode_r && hit_r;

  // result beat and previous answer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      out_found_r <= 1'b0;
      prev_r      <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
      out_found_r <= answer;
      prev_r      <= answer;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_found = out_found_r;

  // status
  assign sts.build_done = (ent_cnt_r == built_cnt_r);
  assign sts.issue_done = (ent_cnt_r == built_cnt_r);
  assign sts.pipe_empty = !rd_vld_r && !cnt_vld_r;
  assign sts.hit        = hit_r;
  assign sts.out_busy   = out_valid_r && out_stall;

endmodule

### hdl/hamming_near_match_search_unit.sv
// top level of the hamming near-match search unit
// build: one generator step per cycle, then the result beat
// query: one stored entry compared per cycle, set by the single store read port;
//   ends early on the first entry within distance
// one item at a time; input is open again in the same cycle a result beat rises, even if it waits
// reset (rst_n low, synchronous) clears registers, generator, answer and control;
//   the store has no reset and is read only where a build has written it
module hamming_near_match_search_unit
  import hnms_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [WORD_W-1:0]    cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_cmd,
  input  logic [WORD_W-1:0]    in_query_word0,
  input  logic [WORD_W-1:0]    in_query_word1,
  input  logic [WORD_W-1:0]    in_query_word2,
  input  logic [WORD_W-1:0]    in_query_word3,
  input  logic [DIST_W-1:0]    in_max_distance,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_found
);

  hnms_cmd_t cmd;
  hnms_sts_t sts;

  // controller
  hnms_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_cmd   (in_cmd),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath
  hnms_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_idx         (cfg_idx),
    .cfg_data        (cfg_data),
    .in_query_word0  (in_query_word0),
    .in_query_word1  (in_query_word1),
    .in_query_word2  (in_query_word2),
    .in_query_word3  (in_query_word3),
    .in_max_distance (in_max_distance),
    .out_valid       (out_valid),
    .out_found       (out_found),
    .out_stall       (out_stall),
    .cmd             (cmd),
    .sts             (sts)
  );

endmodule

### hdl/hnms_checker.sv
// port-level checks of the near-match search unit and their bind
module hnms_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic out_found
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_found))
    else $error("result beat changed while stalled");

  // one item at a time: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted twice in a row");

  // no result beat right after an accept
  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_valid && !in_stall))
    else $error("result appeared one cycle after accept");

  // reset empties the result side
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind hamming_near_match_search_unit hnms_checker u_hnms_checker (.*);

### sim/hamming_near_match_search_unit_tb.sv
// testbench of the hamming near-match search unit: directed table, then random builds and queries
`timescale 1ns / 100ps
module hamming_near_match_search_unit_tb;
  import hnms_pkg::*;

  localparam int CYCLE_LIMIT     = 6_000_000;
  localparam int REPORT_MAX      = 10;
  localparam int ITEMS_PER_PHASE = 36;
  localparam int DRAIN_CYCLES    = 8;
  localparam int TAIL_CYCLES     = 40;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam logic [WORD_W-1:0] COUNT_MASK = (64'd1 << CFG_CNT_W) - 64'd1;
  localparam logic [ROW_W-1:0] ROW_ONES = '1;

  // xorshift128+ shifts and the output bit that feeds each entry bit
  localparam int XS_SHL   = 23;
  localparam int XS_SHR_X = 17;
  localparam int XS_SHR_Y = 26;
  localparam int XS_TAP   = 32;

  typedef enum logic [1:0] {ROW_WRITE, ROW_BUILD, ROW_QUERY, ROW_NEAR} row_kind_t;

  // one line of the directed table
  typedef struct {
    row_kind_t            kind;
    logic [CFG_IDX_W-1:0] idx;
    logic [ROW_W-1:0]     bits;
    logic [DIST_W-1:0]    max_dist;
    int                   ent;
    int                   flips;
    bit                   typed;
    bit                   typed_found;
  } dir_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [WORD_W-1:0]    cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 in_cmd = CMD_BUILD;
  logic [WORD_W-1:0]    in_query_word0 = '0;
  logic [WORD_W-1:0]    in_query_word1 = '0;
  logic [WORD_W-1:0]    in_query_word2 = '0;
  logic [WORD_W-1:0]    in_query_word3 = '0;
  logic [DIST_W-1:0]    in_max_distance = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 out_found;

  // mirror of the registers, generator and store
  logic [WORD_W-1:0]    seed_a_reg = '0;
  logic [WORD_W-1:0]    seed_b_reg = '0;
  logic [CFG_CNT_W-1:0] count_reg = '0;
  logic [WORD_W-1:0]    xs_a = '0;
  logic [WORD_W-1:0]    xs_b = '0;
  logic [ROW_W-1:0]     store_rows [MAX_ENTRIES];
  int                   rows_built = 0;
  bit                   last_found = 1'b0;

  bit       found_q [$];
  dir_row_t dir_tab [$];
  int       cycle_cnt = 0;
  int       err_cnt = 0;
  int       send_pct = 35;
  int       recv_pct = 51;

  hamming_near_match_search_unit u_dut (.*);

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  // one xorshift128+ step
  function automatic logic [WORD_W-1:0] xs_step();
    logic [WORD_W-1:0] x;
    logic [WORD_W-1:0] y;
    x = xs_a;
    y = xs_b;
    xs_a = y;
    x = x ^ (x << XS_SHL);
    xs_b = x ^ y ^ (x >> XS_SHR_X) ^ (y >> XS_SHR_Y);
    return xs_b + y;
  endfunction

  // regenerate the store from the seeds, first bit lands in the msb
  function automatic void fill_store();
    int rows;
    logic [WORD_W-1:0] r;
    rows = (count_reg > MAX_ENTRIES) ? MAX_ENTRIES : int'(count_reg);
    xs_a = seed_a_reg;
    xs_b = seed_b_reg;
    for (int e = 0; e < rows; e++) begin
      for (int b = ROW_W - 1; b >= 0; b--) begin
        r = xs_step();
        store_rows[e][b] = r[XS_TAP];
      end
    end
    rows_built = rows;
    last_found = 1'b0;
  endfunction

  // scan the store for a row within the distance limit
  function automatic bit search_rows(logic [ROW_W-1:0] q_raw, logic [DIST_W-1:0] lim);
    logic [ROW_W-1:0] q;
    bit hit;
    q = last_found ? ~q_raw : q_raw;
    hit = 1'b0;
    for (int e = 0; e < rows_built && !hit; e++) begin
      if ($countones(q ^ store_rows[e]) <= lim) hit = 1'b1;
    end
    last_found = hit;
    return hit;
  endfunction

  // stored row with some bits flipped, pre-inverted when the block will invert it
  function automatic logic [ROW_W-1:0] near_row(int ent, int flips, bit scatter);
    logic [ROW_W-1:0] v;
    int pos;
    v = store_rows[ent];
    for (int i = 0; i < flips; i++) begin
      pos = scatter ? int'($urandom_range(ROW_W - 1, 0)) : (i * 17) % ROW_W;
      v[pos] = ~v[pos];
    end
    return last_found ? ~v : v;
  endfunction

  function automatic logic [ROW_W-1:0] rand_row();
    logic [ROW_W-1:0] v;
    for (int i = 0; i < ROW_W / 32; i++) v[i*32 +: 32] = $urandom();
    return v;
  endfunction

  function automatic logic [WORD_W-1:0] pick_seed();
    case ($urandom_range(5, 0))
      0: return '0;
      1: return '1;
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  function automatic dir_row_t mk_row(row_kind_t kind, logic [CFG_IDX_W-1:0] idx,
                                      logic [ROW_W-1:0] bits, logic [DIST_W-1:0] max_dist,
                                      int ent, int flips, bit typed, bit typed_found);
    dir_row_t r;
    r.kind = kind;
    r.idx = idx;
    r.bits = bits;
    r.max_dist = max_dist;
    r.ent = ent;
    r.flips = flips;
    r.typed = typed;
    r.typed_found = typed_found;
    return r;
  endfunction

  // append one line to the directed table
  function automatic void add_row(dir_row_t r);
    dir_tab = {dir_tab, r};
  endfunction

  // one input beat: random gap, then hold until accepted
  task automatic send_beat(logic cmd, logic [ROW_W-1:0] q, logic [DIST_W-1:0] lim,
                           bit typed, bit typed_found);
    bit want;
    want = (cmd == CMD_BUILD) ? 1'b0 : search_rows(q, lim);
    if (cmd == CMD_BUILD) fill_store();
    if (typed) want = typed_found;
    while ($urandom_range(99, 0) < send_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= cmd;
    {in_query_word0, in_query_word1, in_query_word2, in_query_word3} <= q;
    in_max_distance <= lim;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    found_q = {found_q, want};
  endtask

  // wait until every result beat is back and the block is idle
  task automatic drain_results();
    in_valid <= 1'b0;
    while (found_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // register write, only once the block is idle
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [WORD_W-1:0] data);
    drain_results();
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_SEED_FIRST:  seed_a_reg = data;
      REG_SEED_SECOND: seed_b_reg = data;
      REG_ENTRY_COUNT: count_reg = data[CFG_CNT_W-1:0];
      default: ;
    endcase
  endtask

  // result side stall
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99, 0) < recv_pct);
  end

  // result checker
  always @(posedge clk) begin
    bit want;
    if (rst_n && out_valid && !out_stall) begin
      if (found_q.size() == 0) begin
        if (err_cnt < REPORT_MAX) $display("unexpected result beat: found=%0b", out_found);
        err_cnt = err_cnt + 1;
      end else begin
        want = found_q.pop_front();
        if (out_found !== want) begin
          if (err_cnt < REPORT_MAX)
            $display("found mismatch: expected %0b, got %0b", want, out_found);
          err_cnt = err_cnt + 1;
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("hamming_near_match_search_unit test failed");
      $finish;
    end
  end

  initial begin
    dir_row_t row;
    int sent;
    int n_q;
    int pick;
    int flips;
    int span;
    logic [DIST_W-1:0] lim;
    logic [WORD_W-1:0] raw;

    // query before any build, then a one-entry store of zeros from zero seeds
    add_row(mk_row(ROW_QUERY, '0, ROW_ONES, 4'd15, 0, 0, 1'b1, 1'b0));
    add_row(mk_row(ROW_QUERY, '0, '0, 4'd0, 0, 0, 1'b1, 1'b0));
    add_row(mk_row(ROW_WRITE, REG_ENTRY_COUNT, ROW_W'(64'hFFFF_FFFF_FFFF_E001),
                   '0, 0, 0, 1'b0, 1'b0));
    add_row(mk_row(ROW_BUILD, '0, ROW_ONES, 4'd15, 0, 0, 1'b1, 1'b0));
    add_row(mk_row(ROW_QUERY, '0, '0, 4'd0, 0, 0, 1'b0, 1'b0));
    add_row(mk_row(ROW_QUERY, '0, '0, 4'd15, 0, 0, 1'b0, 1'b0));
    add_row(mk_row(ROW_QUERY, '0, ROW_ONES, 4'd0, 0, 0, 1'b0, 1'b0));
    add_row(mk_row(ROW_QUERY, '0, ROW_W'(15'h7FFF), 4'd15, 0, 0, 1'b0, 1'b0));
    add_row(mk_row(ROW_QUERY, '0, ROW_ONES, 4'd15, 0, 0, 1'b0, 1'b0));
    // unknown index, then a three-entry store
    add_row(mk_row(ROW_WRITE, REG_UNUSED, ROW_ONES, '0, 0, 0, 1'b0, 1'b0));
    add_row(mk_row(ROW_WRITE, REG_SEED_FIRST, ROW_ONES, '0, 0, 0, 1'b0, 1'b0));
    add_row(mk_row(ROW_WRITE, REG_SEED_SECOND, ROW_W'(64'h9E37_79B9_7F4A_7C15),
                   '0, 0, 0, 1'b0, 1'b0));
    add_row(mk_row(ROW_WRITE, REG_ENTRY_COUNT, ROW_W'(3), '0, 0, 0, 1'b0, 1'b0));
    add_row(mk_row(ROW_BUILD, '0, rand_row(), 4'd0, 0, 0, 1'b1, 1'b0));
    add_row(mk_row(ROW_NEAR, '0, '0, 4'd0, 0, 0, 1'b0, 1'b0));
    // rebuild must clear the answer so the next query is not inverted
    add_row(mk_row(ROW_BUILD, '0, rand_row(), 4'd9, 0, 0, 1'b1, 1'b0));
    add_row(mk_row(ROW_NEAR, '0, '0, 4'd0, 0, 0, 1'b0, 1'b0));
    add_row(mk_row(ROW_NEAR, '0, '0, 4'd15, 2, 15, 1'b0, 1'b0));
    add_row(mk_row(ROW_NEAR, '0, '0, 4'd15, 1, 16, 1'b0, 1'b0));
    add_row(mk_row(ROW_NEAR, '0, '0, 4'd4, 1, 5, 1'b0, 1'b0));
    // seed change between builds leaves the store alone
    add_row(mk_row(ROW_WRITE, REG_SEED_FIRST, '0, '0, 0, 0, 1'b0, 1'b0));
    add_row(mk_row(ROW_NEAR, '0, '0, 4'd1, 0, 1, 1'b0, 1'b0));
    // empty store
    add_row(mk_row(ROW_WRITE, REG_ENTRY_COUNT, ROW_W'(MAX_ENTRIES), '0, 0, 0,
                   1'b0, 1'b0));
    add_row(mk_row(ROW_WRITE, REG_ENTRY_COUNT, '0, '0, 0, 0, 1'b0, 1'b0));
    add_row(mk_row(ROW_BUILD, '0, rand_row(), 4'd3, 0, 0, 1'b1, 1'b0));
    add_row(mk_row(ROW_QUERY, '0, '0, 4'd15, 0, 0, 1'b1, 1'b0));
    // count above the store size saturates to a full store
    add_row(mk_row(ROW_WRITE, REG_SEED_FIRST, rand_row(), '0, 0, 0, 1'b0, 1'b0));
    add_row(mk_row(ROW_WRITE, REG_SEED_SECOND, rand_row(), '0, 0, 0, 1'b0, 1'b0));
    add_row(mk_row(ROW_WRITE, REG_ENTRY_COUNT, ROW_W'(COUNT_MASK), '0, 0, 0,
                   1'b0, 1'b0));
    add_row(mk_row(ROW_BUILD, '0, rand_row(), 4'd15, 0, 0, 1'b1, 1'b0));
    add_row(mk_row(ROW_NEAR, '0, '0, 4'd7, MAX_ENTRIES - 1, 7, 1'b0, 1'b0));
    add_row(mk_row(ROW_QUERY, '0, rand_row(), 4'd15, 0, 0, 1'b0, 1'b0));
    add_row(mk_row(ROW_NEAR, '0, '0, 4'd15, 2000, 3, 1'b0, 1'b0));

    // reset
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed table
    foreach (dir_tab[i]) begin
      row = dir_tab[i];
      case (row.kind)
        ROW_WRITE: write_reg(row.idx, row.bits[WORD_W-1:0]);
        ROW_BUILD: send_beat(CMD_BUILD, row.bits, row.max_dist, row.typed, row.typed_found);
        ROW_QUERY: send_beat(CMD_QUERY, row.bits, row.max_dist, row.typed, row.typed_found);
        default:   send_beat(CMD_QUERY, near_row(row.ent, row.flips, 1'b0), row.max_dist,
                             1'b0, 1'b0);
      endcase
    end

    // random sessions: new settings, a build, then mostly near-miss queries
    for (int phase = 0; phase < 3; phase++) begin
      send_pct = (phase == 0) ? 35 : (phase == 1) ? 51 : 0;
      recv_pct = (phase == 0) ? 51 : (phase == 1) ? 35 : 0;
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        if ($urandom_range(3, 0) != 0) write_reg(REG_SEED_FIRST, pick_seed());
        if ($urandom_range(3, 0) != 0) write_reg(REG_SEED_SECOND, pick_seed());
        if ($urandom_range(3, 0) != 0) begin
          raw = {$urandom(), $urandom()};
          write_reg(REG_ENTRY_COUNT, (raw & ~COUNT_MASK) | WORD_W'($urandom_range(12, 0)));
        end
        if ($urandom_range(7, 0) == 0) write_reg(REG_UNUSED, {$urandom(), $urandom()});
        send_beat(CMD_BUILD, rand_row(), DIST_W'($urandom()), 1'b0, 1'b0);
        sent++;
        n_q = $urandom_range(10, 3);
        for (int k = 0; k < n_q; k++) begin
          pick = $urandom_range(9, 0);
          if (pick == 0) begin
            send_beat(CMD_BUILD, rand_row(), DIST_W'($urandom()), 1'b0, 1'b0);
          end else if (pick < 3 || rows_built == 0) begin
            send_beat(CMD_QUERY, rand_row(), DIST_W'($urandom()), 1'b0, 1'b0);
          end else begin
            // limit straddles the number of flipped bits
            flips = $urandom_range(20, 0);
            span = flips - 1 + int'($urandom_range(2, 0));
            if (span < 0) span = 0;
            if (span > 15) span = 15;
            lim = DIST_W'(span);
            send_beat(CMD_QUERY, near_row($urandom_range(rows_built - 1, 0), flips, 1'b1),
                      lim, 1'b0, 1'b0);
          end
          sent++;
        end
      end
    end

    // wind down
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_cnt == 0) begin
      $display("hamming_near_match_search_unit test passed");
    end else begin
      $display("hamming_near_match_search_unit test failed");
    end
    $finish;
  end

endmodule
